// File: design/delayed_event_timer_queue_defines.svh
// ----------------------------------------------------------------------------
// delayed event timer queue assertion macros
// shared property wrappers, clocked on aclk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef DELAYED_EVENT_TIMER_QUEUE_DEFINES_SVH
`define DELAYED_EVENT_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication
`define DTQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// types and codes shared by the timer queue controller and datapath
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int TIME_W      = 32;
    localparam int EVENT_W     = 16;
    localparam int DELAY_W     = 24;
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS);

    localparam logic REQ_POST = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        STAT_ACCEPTED = 2'd0,
        STAT_DROPPED  = 2'd1,
        STAT_FIRED    = 2'd2,
        STAT_NOTHING  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POST,
        ST_TICK
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    load_post;   // latch event and due time of a post
        logic    advance;     // step the time counter
        logic    insert;      // sorted insert into the slot chain
        logic    pop;         // drop the head slot
        logic    out_load;    // load the result register
        status_t out_status;
        logic    out_last;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic head_due;
        logic next_due;
    } stat_t;

endpackage

// File: design/dtq_datapath.sv
// ----------------------------------------------------------------------------
// dtq_datapath
// time counter, sorted slot chain and result register
// ----------------------------------------------------------------------------
`include "delayed_event_timer_queue_defines.svh"

module dtq_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [dtq_pkg::EVENT_W-1:0]   in_event_id,
    input  logic [dtq_pkg::DELAY_W-1:0]   in_delay,
    input  dtq_pkg::cmd_t                 cmd,
    output dtq_pkg::stat_t                stat,
    output logic [1:0]                    out_status,
    output logic [dtq_pkg::EVENT_W-1:0]   out_event,
    output logic                          out_last
);
    import dtq_pkg::*;

    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  due_reg;
    logic [EVENT_W-1:0] ev_reg;

    logic [TIME_W-1:0]  slot_due_reg   [QUEUE_DEPTH];
    logic [EVENT_W-1:0] slot_event_reg [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] slot_valid_reg;

    logic [QUEUE_DEPTH-1:0] shift_w;
    logic [TIME_W-1:0]      head_gap;
    logic [TIME_W-1:0]      next_gap;

    logic [1:0]         out_status_reg;
    logic [EVENT_W-1:0] out_event_reg;
    logic               out_last_reg;

    // time counter and latched post
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg <= '0;
        end else if (cmd.advance) begin
            now_reg <= now_reg + TIME_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_post) begin
            ev_reg  <= in_event_id;
            due_reg <= now_reg + {{(TIME_W-DELAY_W){1'b0}}, in_delay};
        end
    end

    // one lane per slot: insert moves later entries up, pop moves all down
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_lane
        logic [TIME_W-1:0]  gap;
        logic               prev_shift;
        logic               up_valid;
        logic [TIME_W-1:0]  ins_due;
        logic [EVENT_W-1:0] ins_event;
        logic [TIME_W-1:0]  dn_due;
        logic [EVENT_W-1:0] dn_event;
        logic               dn_valid;

        assign gap        = due_reg - slot_due_reg[g];
        // slot lies strictly after the new due time, or is free
        assign shift_w[g] = !slot_valid_reg[g] || gap[TIME_W-1];

        if (g == 0) begin : g_first
            assign prev_shift = 1'b0;
            assign up_valid   = 1'b1;
            assign ins_due    = due_reg;
            assign ins_event  = ev_reg;
        end else begin : g_rest
            assign prev_shift = shift_w[g-1];
            assign up_valid   = slot_valid_reg[g-1];
            assign ins_due    = prev_shift ? slot_due_reg[g-1] : due_reg;
            assign ins_event  = prev_shift ? slot_event_reg[g-1] : ev_reg;
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign dn_due   = slot_due_reg[g];
            assign dn_event = slot_event_reg[g];
            assign dn_valid = 1'b0;
        end else begin : g_body
            assign dn_due   = slot_due_reg[g+1];
            assign dn_event = slot_event_reg[g+1];
            assign dn_valid = slot_valid_reg[g+1];
        end

        always_ff @(posedge aclk) begin
            if (cmd.insert && shift_w[g]) begin
                slot_due_reg[g]   <= ins_due;
                slot_event_reg[g] <= ins_event;
            end else if (cmd.pop) begin
                slot_due_reg[g]   <= dn_due;
                slot_event_reg[g] <= dn_event;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                slot_valid_reg[g] <= 1'b0;
            end else if (cmd.insert) begin
                slot_valid_reg[g] <= slot_valid_reg[g] | up_valid;
            end else if (cmd.pop) begin
                slot_valid_reg[g] <= dn_valid;
            end
        end
    end

    // due when now minus due time is zero or positive
    assign head_gap      = now_reg - slot_due_reg[0];
    assign next_gap      = now_reg - slot_due_reg[1];
    assign stat.full     = slot_valid_reg[QUEUE_DEPTH-1];
    assign stat.head_due = slot_valid_reg[0] && !head_gap[TIME_W-1];
    assign stat.next_due = slot_valid_reg[1] && !next_gap[TIME_W-1];

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg <= cmd.out_status;
            out_event_reg  <= (cmd.out_status == STAT_FIRED) ? slot_event_reg[0] : '0;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign out_status = out_status_reg;
    assign out_event  = out_event_reg;
    assign out_last   = out_last_reg;

    `DTQ_ASSERT_NEXT(a_insert_fills, cmd.insert, slot_valid_reg[0], "insert left store empty")
    `DTQ_ASSERT_NOW(a_valid_prefix, !slot_valid_reg[0], !slot_valid_reg[1], "valid slots not a prefix")
    `DTQ_ASSERT_NOW(a_pop_nonempty, cmd.pop, slot_valid_reg[0], "pop on an empty store")
    `DTQ_ASSERT_NOW(a_insert_room, cmd.insert, !slot_valid_reg[QUEUE_DEPTH-1], "insert into full store")

endmodule

// File: design/dtq_ctrl.sv
// ----------------------------------------------------------------------------
// dtq_ctrl
// transaction sequencing for posts and ticks, result valid and fire count
// ----------------------------------------------------------------------------
`include "delayed_event_timer_queue_defines.svh"

module dtq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_req_type,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  dtq_pkg::stat_t stat,
    output dtq_pkg::cmd_t  cmd
);
    import dtq_pkg::*;

    state_t                state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    logic [FIRE_CNT_W-1:0] fire_cnt_reg, fire_cnt_next;
    logic                  out_free;
    logic                  at_limit;

    assign out_free = !m_valid_reg || m_ready;
    assign at_limit = (fire_cnt_reg == FIRE_CNT_W'(MAX_RESULTS - 1));
    // a waiting result does not block the next transaction from being taken
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            fire_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            fire_cnt_reg <= fire_cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        fire_cnt_next = fire_cnt_reg;
        cmd           = '0;
        cmd.out_status = STAT_ACCEPTED;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_req_type == REQ_TICK) begin
                        cmd.advance   = 1'b1;
                        fire_cnt_next = '0;
                        state_next    = ST_TICK;
                    end else begin
                        cmd.load_post = 1'b1;
                        state_next    = ST_POST;
                    end
                end
            end
            ST_POST: begin
                if (out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.insert     = !stat.full;
                    cmd.out_status = stat.full ? STAT_DROPPED : STAT_ACCEPTED;
                    state_next     = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    if (stat.head_due) begin
                        cmd.pop        = 1'b1;
                        cmd.out_status = STAT_FIRED;
                        cmd.out_last   = !stat.next_due || at_limit;
                        fire_cnt_next  = fire_cnt_reg + FIRE_CNT_W'(1);
                        if (cmd.out_last) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        cmd.out_status = STAT_NOTHING;
                        cmd.out_last   = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    `DTQ_ASSERT_NOW(a_pop_due, cmd.pop, stat.head_due, "popped an entry that is not due")
    `DTQ_ASSERT_NOW(a_limit_last, cmd.pop && at_limit, cmd.out_last, "fire limit without last")
    `DTQ_ASSERT_NOW(a_load_free, cmd.out_load, !m_valid_reg || m_ready, "result overwritten")
    `DTQ_ASSERT_NEXT(a_accept_busy, s_valid && s_ready, !s_ready, "second transaction taken")

endmodule

// File: design/delayed_event_timer_queue.sv
// ----------------------------------------------------------------------------
// delayed_event_timer_queue
// delayed-event scheduler with a sorted fixed-capacity store and a tick clock
// ----------------------------------------------------------------------------
// A post transaction (req_type 0) schedules event_id to fall due delay ticks
// after the current time and answers one result: accepted, or dropped when
// all QUEUE_DEPTH slots are in use. A tick transaction (req_type 1) advances
// the 32-bit wrapping time counter and then fires every stored event that is
// due, earliest first and in posting order among equal due times, at most 16
// per tick, with last on the final one; a tick with nothing due answers one
// "nothing due" result. A post latches the event and adds the due time,
// then does the sorted insert across the slot chain when the result
// register is free; a tick advances the counter, then pops the head of the
// chain into the single result register once a cycle while it is free.
// A new transaction is taken once the previous one has placed its last
// result, and the result register may still hold that result meanwhile.
// ----------------------------------------------------------------------------
module delayed_event_timer_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [15:0] s_event_id,
    input  logic [23:0] s_delay,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_fired_event,
    output logic        m_last
);
    import dtq_pkg::*;

    // command and status between sequencer and datapath
    cmd_t  cmd;
    stat_t stat;

    // sequencer: idle, post insert, tick pop loop, result valid
    dtq_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // time counter, sorted slot chain, result register
    dtq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_event_id (s_event_id),
        .in_delay    (s_delay),
        .cmd         (cmd),
        .stat        (stat),
        .out_status  (m_status),
        .out_event   (m_fired_event),
        .out_last    (m_last)
    );

endmodule
